FILE: hw/rtl/cdit_pkg.sv
// ----------------------------------------------------------------------------
// cdit_pkg
// Shared types, constants and helpers for the coordinate dedupe index table.
// ----------------------------------------------------------------------------
package cdit_pkg;

  localparam int MAX_CELLS     = 4096;
  localparam int BUCKETS       = 8192;

  localparam int OP_W          = 2;
  localparam int COORD_W       = 16;
  localparam int KEY_W         = 3 * COORD_W;
  localparam int CELL_INDEX_W  = 12;
  localparam int STATUS_W      = 3;
  localparam int ENTRY_COUNT_W = 13;

  localparam int IDX_W  = $clog2(MAX_CELLS);
  localparam int CNT_W  = $clog2(MAX_CELLS + 1);
  localparam int BKT_AW = $clog2(BUCKETS);

  // Only product bits up to the top hash bit matter; split into two halves
  // so each partial product stays a narrow multiply.
  localparam int PROD_W = 32 + BKT_AW;
  localparam int LO_W   = (PROD_W + 1) / 2;
  localparam int HI_W   = PROD_W - LO_W;

  localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
  } req_item_t;

  typedef struct packed {
    logic [CELL_INDEX_W-1:0]  cell_index;
    logic [STATUS_W-1:0]      status;
    logic                     full_flag;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } rsp_item_t;

  typedef enum logic [1:0] {
    MUL_K0C0,
    MUL_K0C1,
    MUL_K1C0
  } mul_sel_t;

  typedef enum logic [1:0] {
    IDX_ZERO,
    IDX_HIT,
    IDX_NEW
  } idx_src_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_BKT_WAIT,
    S_BKT_CHK,
    S_KEY_WAIT,
    S_KEY_CHK,
    S_MISS,
    S_CLR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                capture;
    logic                mul_en;
    mul_sel_t            mul_sel;
    logic                acc_load;
    logic                acc_add;
    logic                ptr_load;
    logic                ptr_adv;
    logic                entry_load;
    logic                slot_set;
    logic                slot_clr;
    logic                insert;
    logic                set_full;
    logic                clr_start;
    logic                clr_step;
    logic                clr_regs;
    logic                res_load;
    idx_src_t            res_src;
    logic [STATUS_W-1:0] res_status;
    logic                out_load;
  } cdit_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            bkt_empty;
    logic            key_match;
    logic            probe_last;
    logic            cap_full;
    logic            has_slot;
    logic            clr_last;
  } cdit_stat_t;

  // Zero-extend or truncate the packed key to the product width.
  function automatic logic [PROD_W-1:0] key_ext(input logic [KEY_W-1:0] key);
    logic [PROD_W-1:0] r;
    r = '0;
    for (int i = 0; i < PROD_W; i++) begin
      if (i < KEY_W) begin
        r[i] = key[i];
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/cdit_ram.sv
// ----------------------------------------------------------------------------
// cdit_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/cdit_datapath.sv
// ----------------------------------------------------------------------------
// cdit_datapath
// Key hashing, bucket and coordinate memories, counters and result register.
// ----------------------------------------------------------------------------
module cdit_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  cdit_pkg::req_item_t  req,
  input  cdit_pkg::cdit_cmd_t  cmd,
  output cdit_pkg::cdit_stat_t stat,
  output cdit_pkg::rsp_item_t  rsp
);
  import cdit_pkg::*;

  logic [OP_W-1:0]     op_reg;
  logic [KEY_W-1:0]    key;
  logic [PROD_W-1:0]   k_ext;
  logic [LO_W-1:0]     mul_a;
  logic [LO_W-1:0]     mul_b;
  logic [2*LO_W-1:0]   pp;
  logic [PROD_W-1:0]   acc;
  logic [PROD_W-1:0]   acc_sum;
  logic [BKT_AW-1:0]   ptr;
  logic [BKT_AW-1:0]   probe_n;
  logic [CNT_W-1:0]    entry;
  logic [CNT_W-1:0]    entry_m1;
  logic                has_slot;
  logic [CNT_W-1:0]    count;
  logic                full;
  logic [BKT_AW-1:0]   clr_ptr;
  logic [IDX_W-1:0]    res_idx;
  logic [STATUS_W-1:0] res_status;

  logic                bkt_we;
  logic [BKT_AW-1:0]   bkt_waddr;
  logic [CNT_W-1:0]    bkt_wdata;
  logic [CNT_W-1:0]    bkt_q;
  logic [KEY_W-1:0]    coord_q;

  assign k_ext    = key_ext(key);
  assign acc_sum  = acc + {pp[HI_W-1:0], {LO_W{1'b0}}};
  assign entry_m1 = entry - CNT_W'(1);

  always_comb begin
    case (cmd.mul_sel)
      MUL_K0C0: begin
        mul_a = k_ext[LO_W-1:0];
        mul_b = HASH_MULT[LO_W-1:0];
      end
      MUL_K0C1: begin
        mul_a = k_ext[LO_W-1:0];
        mul_b = LO_W'(HASH_MULT[PROD_W-1:LO_W]);
      end
      MUL_K1C0: begin
        mul_a = LO_W'(k_ext[PROD_W-1:LO_W]);
        mul_b = HASH_MULT[LO_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_reg <= req.op;
      key    <= {req.x_coord, req.y_coord, req.z_coord};
    end
    if (cmd.mul_en) begin
      pp <= (2*LO_W)'(mul_a) * (2*LO_W)'(mul_b);
    end
    if (cmd.acc_load) begin
      acc <= pp[PROD_W-1:0];
    end else if (cmd.acc_add) begin
      acc <= acc_sum;
    end
    if (cmd.ptr_load) begin
      ptr     <= acc_sum[PROD_W-1:32];
      probe_n <= '0;
    end else if (cmd.ptr_adv) begin
      ptr     <= (ptr == BKT_AW'(BUCKETS - 1)) ? '0 : ptr + BKT_AW'(1);
      probe_n <= probe_n + BKT_AW'(1);
    end
    if (cmd.entry_load) begin
      entry <= bkt_q;
    end
    if (cmd.slot_set) begin
      has_slot <= 1'b1;
    end else if (cmd.slot_clr) begin
      has_slot <= 1'b0;
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      case (cmd.res_src)
        IDX_HIT:  res_idx <= entry_m1[IDX_W-1:0];
        IDX_NEW:  res_idx <= count[IDX_W-1:0];
        default:  res_idx <= '0;
      endcase
    end
    if (cmd.out_load) begin
      rsp.cell_index  <= CELL_INDEX_W'(res_idx);
      rsp.status      <= res_status;
      rsp.full_flag   <= full;
      rsp.entry_count <= ENTRY_COUNT_W'(count);
    end
  end

  // table state
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      full    <= 1'b0;
      clr_ptr <= '0;
    end else begin
      if (cmd.clr_regs) begin
        count <= '0;
        full  <= 1'b0;
      end else if (cmd.insert) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.set_full) begin
        full <= 1'b1;
      end
      if (cmd.clr_start) begin
        clr_ptr <= '0;
      end else if (cmd.clr_step) begin
        clr_ptr <= stat.clr_last ? '0 : clr_ptr + BKT_AW'(1);
      end
    end
  end

  // empty buckets during a sweep, else record the new cell in the free slot
  assign bkt_we    = cmd.clr_step | cmd.insert;
  assign bkt_waddr = cmd.clr_step ? clr_ptr : ptr;
  assign bkt_wdata = cmd.clr_step ? '0 : count + CNT_W'(1);

  cdit_ram #(
    .WIDTH (CNT_W),
    .DEPTH (BUCKETS)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .raddr (ptr),
    .rdata (bkt_q)
  );

  cdit_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_CELLS)
  ) u_coord_ram (
    .clk   (clk),
    .we    (cmd.insert),
    .waddr (count[IDX_W-1:0]),
    .wdata (key),
    .raddr (entry_m1[IDX_W-1:0]),
    .rdata (coord_q)
  );

  assign stat.op         = op_reg;
  assign stat.bkt_empty  = (bkt_q == '0);
  assign stat.key_match  = (coord_q == key);
  assign stat.probe_last = (probe_n == BKT_AW'(BUCKETS - 1));
  assign stat.cap_full   = (count >= CNT_W'(MAX_CELLS));
  assign stat.has_slot   = has_slot;
  assign stat.clr_last   = (clr_ptr == BKT_AW'(BUCKETS - 1));

endmodule

FILE: hw/rtl/cdit_ctrl.sv
// ----------------------------------------------------------------------------
// cdit_ctrl
// Sequencer for hashing, probing, insert and bucket sweeps; owns handshakes.
// ----------------------------------------------------------------------------
module cdit_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  input  logic [cdit_pkg::OP_W-1:0] req_op,
  output logic                    req_stall,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  input  cdit_pkg::cdit_stat_t    stat,
  output cdit_pkg::cdit_cmd_t     cmd
);
  import cdit_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          if (req_op == OP_CLEAR) begin
            cmd.clr_start = 1'b1;
            state_next    = S_CLR;
          end else begin
            state_next = S_MUL0;
          end
        end
      end
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_K0C0;
        state_next  = S_MUL1;
      end
      S_MUL1: begin
        cmd.acc_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_K0C1;
        state_next   = S_MUL2;
      end
      S_MUL2: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_K1C0;
        state_next  = S_MUL3;
      end
      S_MUL3: begin
        cmd.ptr_load = 1'b1;
        state_next   = S_BKT_WAIT;
      end
      S_BKT_WAIT: begin
        state_next = S_BKT_CHK;
      end
      S_BKT_CHK: begin
        if (stat.bkt_empty) begin
          cmd.slot_set = 1'b1;
          state_next   = S_MISS;
        end else begin
          cmd.entry_load = 1'b1;
          state_next     = S_KEY_WAIT;
        end
      end
      S_KEY_WAIT: begin
        state_next = S_KEY_CHK;
      end
      S_KEY_CHK: begin
        if (stat.key_match) begin
          cmd.res_load   = 1'b1;
          cmd.res_src    = IDX_HIT;
          cmd.res_status = ST_FOUND;
          state_next     = S_DONE;
        end else if (stat.probe_last) begin
          // every bucket visited without a hit or a free slot
          cmd.slot_clr = 1'b1;
          state_next   = S_MISS;
        end else begin
          cmd.ptr_adv = 1'b1;
          state_next  = S_BKT_WAIT;
        end
      end
      S_MISS: begin
        cmd.res_load = 1'b1;
        state_next   = S_DONE;
        if (stat.op != OP_ADD) begin
          cmd.res_src    = IDX_ZERO;
          cmd.res_status = ST_MISS;
        end else if (stat.cap_full || !stat.has_slot) begin
          cmd.set_full   = 1'b1;
          cmd.res_src    = IDX_ZERO;
          cmd.res_status = ST_FULL;
        end else begin
          cmd.insert     = 1'b1;
          cmd.res_src    = IDX_NEW;
          cmd.res_status = ST_INSERTED;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          cmd.clr_regs   = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_src    = IDX_ZERO;
          cmd.res_status = ST_CLEARED;
          state_next     = S_DONE;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

FILE: hw/rtl/coordinate_dedupe_index_table_core.sv
// ----------------------------------------------------------------------------
// coordinate_dedupe_index_table_core
// Hash table that maps signed 3D coordinates to dense sequential indices.
// ----------------------------------------------------------------------------
// One item is worked at a time. An add or find is accepted, then hashed in
// states S_MUL0 to S_MUL3 on a shared 23x23 multiplier. Each bucket probed
// is read from the bucket RAM; an empty bucket ends the probe, while an
// occupied one leads to a coordinate RAM read and compare, and a collision
// moves the probe on to the next bucket. After a miss the block decides and
// loads the result, then the output register; after a hit it loads the
// output register. A clear sweeps the bucket RAM one entry a cycle. After
// reset the same sweep runs with req_stall high. The output register lets
// the next item enter while the previous result waits to be taken.
// ----------------------------------------------------------------------------
module coordinate_dedupe_index_table_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  cdit_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output cdit_pkg::rsp_item_t rsp
);
  import cdit_pkg::*;

  cdit_cmd_t  cmd;
  cdit_stat_t stat;

  cdit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (req.op),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  cdit_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

FILE: bench/coordinate_dedupe_index_table_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coordinate_dedupe_index_table_core_tb
// Drives add, find, clear and unused-op items into the coordinate index table.
// A scoreboard class keeps its own hash table with linear probing and checks
// every result field. The run has a directed opening, a random mix with reused
// keys and forced bucket collisions, and a closing burst with no idling.
// ----------------------------------------------------------------------------
module coordinate_dedupe_index_table_core_tb;
  import cdit_pkg::*;

  // op code 3 is not decoded by the block and acts as a find
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1500;
  localparam int TAIL_ITEMS   = 220;

  class cell_index_scoreboard;
    int unsigned      bucket_ref [BUCKETS];   // cell index plus one, 0 = empty
    logic [KEY_W-1:0] cell_key [MAX_CELLS];
    int unsigned      n_assigned;
    bit               overflow;
    rsp_item_t        pending_answers [$];
    int unsigned      errors;
    int unsigned      n_accepted;
    int unsigned      n_checked;
    int unsigned      seen_status [8];
    int unsigned      peak_count;
    bit               flag_seen;

    function new();
      empty_table();
    endfunction

    static function int unsigned bucket_of(logic [KEY_W-1:0] key);
      logic [63:0] prod;
      prod = {16'd0, key} * HASH_MULT;
      return 32'((prod >> 32) % BUCKETS);
    endfunction

    function void empty_table();
      foreach (bucket_ref[i]) bucket_ref[i] = 0;
      n_assigned = 0;
      overflow   = 1'b0;
    endfunction

    // Work out the answer for an accepted item and update the table.
    function void apply_request(req_item_t item);
      rsp_item_t        want;
      logic [KEY_W-1:0] key;
      int unsigned      b, n, e, slot, idx;
      bit               hit, has_slot;
      want = '0;
      n_accepted++;
      if (item.op == OP_CLEAR) begin
        empty_table();
        want.status = ST_CLEARED;
      end else begin
        key      = {item.x_coord, item.y_coord, item.z_coord};
        b        = bucket_of(key);
        hit      = 1'b0;
        has_slot = 1'b0;
        idx      = 0;
        slot     = 0;
        for (n = 0; n < BUCKETS && !hit && !has_slot; n++) begin
          e = bucket_ref[b];
          if (e == 0) begin
            has_slot = 1'b1;
            slot     = b;
          end else if (cell_key[e-1] == key) begin
            hit = 1'b1;
            idx = e - 1;
          end else begin
            b = (b + 1) % BUCKETS;
          end
        end
        if (hit) begin
          want.status = ST_FOUND;
        end else if (item.op != OP_ADD) begin
          idx         = 0;
          want.status = ST_MISS;
        end else if (n_assigned >= MAX_CELLS || !has_slot) begin
          overflow    = 1'b1;
          idx         = 0;
          want.status = ST_FULL;
        end else begin
          idx              = n_assigned;
          cell_key[idx]    = key;
          bucket_ref[slot] = idx + 1;
          n_assigned++;
          want.status      = ST_INSERTED;
        end
        want.cell_index = idx[CELL_INDEX_W-1:0];
      end
      want.full_flag   = overflow;
      want.entry_count = n_assigned[ENTRY_COUNT_W-1:0];
      pending_answers.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_answer(rsp_item_t got);
      rsp_item_t want;
      n_checked++;
      if (pending_answers.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", n_checked));
        return;
      end
      want = pending_answers.pop_front();
      if (got.cell_index !== want.cell_index)
        report($sformatf("result %0d cell_index %0d, expected %0d",
                         n_checked, got.cell_index, want.cell_index));
      if (got.status !== want.status)
        report($sformatf("result %0d status %0d, expected %0d",
                         n_checked, got.status, want.status));
      if (got.full_flag !== want.full_flag)
        report($sformatf("result %0d full_flag %0b, expected %0b",
                         n_checked, got.full_flag, want.full_flag));
      if (got.entry_count !== want.entry_count)
        report($sformatf("result %0d entry_count %0d, expected %0d",
                         n_checked, got.entry_count, want.entry_count));
      seen_status[want.status]++;
      if (want.entry_count > peak_count) peak_count = 32'(want.entry_count);
      if (want.full_flag) flag_seen = 1'b1;
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  cell_index_scoreboard sb;
  bit                   idle_on = 1'b1;
  logic [KEY_W-1:0]     key_pool [$];

  coordinate_dedupe_index_table_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic req_item_t make_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
    req_item_t it;
    it.op      = op;
    it.x_coord = key[47:32];
    it.y_coord = key[31:16];
    it.z_coord = key[15:0];
    return it;
  endfunction

  // Find a random key whose home bucket lies in the four buckets from home.
  function automatic logic [KEY_W-1:0] key_near(int unsigned home);
    logic [KEY_W-1:0] k;
    do begin
      k[47:32] = 16'($urandom);
      k[31:0]  = $urandom;
    end while ((cell_index_scoreboard::bucket_of(k) + BUCKETS - home) % BUCKETS >= 4);
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pool_key();
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  task automatic send_item(req_item_t item);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.apply_request(item);
    if (item.op != OP_CLEAR) begin
      key_pool.push_back({item.x_coord, item.y_coord, item.z_coord});
      if (key_pool.size() > 512) key_pool.delete(0);
    end
  endtask

  // Hold the sender until every outstanding answer is back.
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_answers.size() != 0);
  endtask

  task automatic random_item();
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] k;
    logic [15:0]      c;
    int unsigned      sel;
    sel = $urandom_range(0, 99);
    if (sel < 1)       op = OP_CLEAR;
    else if (sel < 4)  op = OP_UNUSED;
    else if (sel < 34) op = OP_FIND;
    else               op = OP_ADD;
    sel = $urandom_range(0, 9);
    if (sel < 5 && key_pool.size() != 0) begin
      k = pool_key();
    end else if (sel < 7 && key_pool.size() != 0) begin
      k = key_near(cell_index_scoreboard::bucket_of(pool_key()));
    end else if (sel == 7) begin
      k = '0;
      for (int j = 0; j < 3; j++) begin
        case ($urandom_range(0, 4))
          0:       c = 16'h8000;
          1:       c = 16'h7FFF;
          2:       c = 16'hFFFF;
          3:       c = 16'h0000;
          default: c = 16'h0001;
        endcase
        k = {k[31:0], c};
      end
    end else begin
      k[47:32] = 16'($urandom);
      k[31:0]  = $urandom;
    end
    send_item(make_item(op, k));
  endtask

  // Take results, stall the result side in random bursts.
  initial begin : answer_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) sb.check_answer(rsp);
      if (hold_left == 0 && idle_on && $urandom_range(0, 9) == 0)
        hold_left = $urandom_range(1, 10);
      if (hold_left != 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #40_000_000;
    $display("** coordinate_dedupe_index_table_core: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [KEY_W-1:0] k;
    int unsigned      waited;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed opening: empty table, extreme coordinates, every op, collisions
    send_item(make_item(OP_FIND,   48'h0));
    send_item(make_item(OP_ADD,    48'h0));
    send_item(make_item(OP_ADD,    {16'h7FFF, 16'h7FFF, 16'h7FFF}));
    send_item(make_item(OP_ADD,    {16'h8000, 16'h8000, 16'h8000}));
    send_item(make_item(OP_ADD,    {16'hFFFF, 16'h0001, 16'h8000}));
    send_item(make_item(OP_ADD,    48'h0));
    send_item(make_item(OP_FIND,   {16'h7FFF, 16'h7FFF, 16'h7FFF}));
    send_item(make_item(OP_UNUSED, {16'h8000, 16'h8000, 16'h8000}));
    send_item(make_item(OP_UNUSED, {16'h0001, 16'h0002, 16'h0003}));
    send_item(make_item(OP_FIND,   {16'hFFFF, 16'hFFFF, 16'hFFFF}));
    k = key_near(cell_index_scoreboard::bucket_of(48'h0));
    send_item(make_item(OP_ADD,    k));
    send_item(make_item(OP_ADD,    key_near(cell_index_scoreboard::bucket_of(48'h0))));
    send_item(make_item(OP_FIND,   k));
    send_item(make_item(OP_ADD,    k));
    send_item(make_item(OP_CLEAR,  48'h0));
    send_item(make_item(OP_FIND,   48'h0));
    send_item(make_item(OP_ADD,    {16'h8000, 16'h7FFF, 16'h0000}));
    send_item(make_item(OP_CLEAR,  48'h0));
    send_item(make_item(OP_CLEAR,  48'h0));
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 250 == 0) idle_on = ($urandom_range(0, 3) != 0);
      random_item();
    end
    drain();

    // closing burst; no idling on either side from here
    idle_on = 1'b0;
    for (int i = 0; i < TAIL_ITEMS; i++) begin
      random_item();
    end
    send_item(make_item(OP_FIND,   {16'hFFFF, 16'h8000, 16'h7FFF}));
    send_item(make_item(OP_CLEAR,  48'h0));
    send_item(make_item(OP_ADD,    {16'h7FFF, 16'h8000, 16'hFFFF}));
    req_valid <= 1'b0;

    waited = 0;
    while (sb.pending_answers.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (sb.pending_answers.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_answers.size()));

    $display("covered %0d items, %0d results: %0d hits, %0d inserts, %0d misses",
             sb.n_accepted, sb.n_checked, sb.seen_status[ST_FOUND],
             sb.seen_status[ST_INSERTED], sb.seen_status[ST_MISS]);
    $display("  %0d table-full answers, %0d clears, peak count %0d, full flag seen %0b",
             sb.seen_status[ST_FULL], sb.seen_status[ST_CLEARED], sb.peak_count,
             sb.flag_seen);
    if (sb.errors == 0) begin
      $display("** coordinate_dedupe_index_table_core: PASSED **");
    end else begin
      $display("** coordinate_dedupe_index_table_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/cdit_pkg.sv
hw/rtl/cdit_ram.sv
hw/rtl/cdit_datapath.sv
hw/rtl/cdit_ctrl.sv
hw/rtl/coordinate_dedupe_index_table_core.sv
bench/coordinate_dedupe_index_table_core_tb.sv
